@@ design/rpt_pkg.sv @@
// Shared types, codes and constants for the replication progress tracker.
package rpt_pkg;

  localparam int unsigned IDX_W = 64;
  localparam int unsigned ACT_W = 4;
  localparam int unsigned MODE_W = 2;

  localparam logic [IDX_W-1:0] IDX_ONE = {{(IDX_W-1){1'b0}}, 1'b1};

  // Action codes; codes above ACT_LOAD behave as a query.
  localparam logic [ACT_W-1:0] ACT_QUERY      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_REPLICATE  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SNAPSHOT   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_UPDATE     = 4'd4;
  localparam logic [ACT_W-1:0] ACT_OPTIMISTIC = 4'd5;
  localparam logic [ACT_W-1:0] ACT_REJECT     = 4'd6;
  localparam logic [ACT_W-1:0] ACT_PROBE_FLAG = 4'd7;
  localparam logic [ACT_W-1:0] ACT_ACTIVE     = 4'd8;
  localparam logic [ACT_W-1:0] ACT_LOAD       = 4'd9;

  localparam logic [MODE_W-1:0] MODE_PROBE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLICATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SNAPSHOT  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] hint;
    logic             flag_value;
    logic             window_full;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  next_idx;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  snap_idx;
    logic              probe_pending;
    logic              active;
  } track_state_t;

  typedef struct packed {
    logic success;
    logic paused;
    logic clear_window;
  } status_t;

endpackage

@@ design/replication_progress_tracker.sv @@
// Top level of the replication progress tracker: state, result register and handshakes.
//
// Tracks one follower's replication progress (mode, match, next, pending
// snapshot, probe-sent and recently-active flags). Every accepted item yields
// exactly one result carrying the state after its action plus success, paused
// and a clear_window pulse. Throughput is one item per clock while out_ready
// keeps the result register draining. The result shows on out_valid once the
// item has passed the input register and then the update logic into the result
// register. The state loop through rpt_update and the st_r register sets the
// rate: each item reads the state left by the one before it. in_ready stays
// high while the input register is empty or its item moves on this cycle; with
// both the input register and the result register full and out_ready low,
// intake stops until the result drains. All index arithmetic wraps modulo 2^64;
// action codes 10 to 15 act as a query.
module replication_progress_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_action,
  input  logic [63:0] in_index,
  input  logic [63:0] in_hint,
  input  logic        in_flag_value,
  input  logic        in_window_full,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mode,
  output logic [63:0] out_match_index,
  output logic [63:0] out_next_index,
  output logic [63:0] out_snapshot_index,
  output logic        out_success,
  output logic        out_paused,
  output logic        out_clear_window,
  output logic        out_recently_active
);

  rpt_pkg::item_t        in_item;
  rpt_pkg::item_t        item;
  logic                  item_valid;
  logic                  take;
  rpt_pkg::track_state_t st_r;
  rpt_pkg::track_state_t st_nxt;
  rpt_pkg::status_t      status;
  rpt_pkg::track_state_t res_st_r;
  rpt_pkg::status_t      res_stat_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  assign in_item.action      = in_action;
  assign in_item.index       = in_index;
  assign in_item.hint        = in_hint;
  assign in_item.flag_value  = in_flag_value;
  assign in_item.window_full = in_window_full;

  // The held item moves on when the result slot is empty or drains this cycle.
  assign take = item_valid && (!out_valid_r || out_ready);

  rpt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rpt_update u_update (
    .item   (item),
    .st     (st_r),
    .st_nxt (st_nxt),
    .status (status)
  );

  // Tracker state: committed only when the item's result is captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  assign out_valid_nxt = take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_st_r   <= st_nxt;
      res_stat_r <= status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = res_st_r.mode;
  assign out_match_index     = res_st_r.match_idx;
  assign out_next_index      = res_st_r.next_idx;
  assign out_snapshot_index  = res_st_r.snap_idx;
  assign out_success         = res_stat_r.success;
  assign out_paused          = res_stat_r.paused;
  assign out_clear_window    = res_stat_r.clear_window;
  assign out_recently_active = res_st_r.active;

  // Mode changes never report success.
  a_clr_no_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_clear_window && out_success))
    else $error("clear_window and success both set");

  // Snapshot mode always pauses sending.
  a_snap_paused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode == rpt_pkg::MODE_SNAPSHOT) |-> out_paused)
    else $error("snapshot mode not paused");

  // Entering probe or replicate drops any pending snapshot.
  a_clr_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clear_window && out_mode != rpt_pkg::MODE_SNAPSHOT)
      |-> out_snapshot_index == '0)
    else $error("pending snapshot kept after mode change");

  // A held item is never dropped while the result slot is blocked.
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !take) |=> item_valid)
    else $error("input item lost while stalled");

  // State only moves when a result is captured.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(st_r))
    else $error("tracker state changed without a transfer");

endmodule

@@ design/rpt_in_reg.sv @@
// Input register stage: holds one accepted item until the update logic takes it.
module rpt_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpt_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output rpt_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  rpt_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ design/rpt_update.sv @@
// Next-state and status logic for one action applied to the tracker state.
module rpt_update (
  input  rpt_pkg::item_t        item,
  input  rpt_pkg::track_state_t st,
  output rpt_pkg::track_state_t st_nxt,
  output rpt_pkg::status_t      status
);

  logic [rpt_pkg::IDX_W-1:0] match_inc;
  logic [rpt_pkg::IDX_W-1:0] snap_inc;
  logic [rpt_pkg::IDX_W-1:0] idx_inc;
  logic [rpt_pkg::IDX_W-1:0] hint_inc;
  logic [rpt_pkg::IDX_W-1:0] next_dec;
  logic [rpt_pkg::IDX_W-1:0] hint_min;
  logic                      success;
  logic                      clr;

  assign match_inc = st.match_idx + rpt_pkg::IDX_ONE;
  assign snap_inc  = st.snap_idx + rpt_pkg::IDX_ONE;
  assign idx_inc   = item.index + rpt_pkg::IDX_ONE;
  assign hint_inc  = item.hint + rpt_pkg::IDX_ONE;
  assign next_dec  = st.next_idx - rpt_pkg::IDX_ONE;
  assign hint_min  = (item.index < hint_inc) ? item.index : hint_inc;

  always_comb begin
    st_nxt  = st;
    success = 1'b0;
    clr     = 1'b0;
    unique case (item.action)
      rpt_pkg::ACT_PROBE: begin
        st_nxt.mode          = rpt_pkg::MODE_PROBE;
        st_nxt.probe_pending = 1'b0;
        st_nxt.snap_idx      = '0;
        clr                  = 1'b1;
        // leaving snapshot: resume past whichever is further
        if (st.mode == rpt_pkg::MODE_SNAPSHOT && snap_inc > match_inc) begin
          st_nxt.next_idx = snap_inc;
        end else begin
          st_nxt.next_idx = match_inc;
        end
      end
      rpt_pkg::ACT_REPLICATE: begin
        st_nxt.mode          = rpt_pkg::MODE_REPLICATE;
        st_nxt.probe_pending = 1'b0;
        st_nxt.snap_idx      = '0;
        st_nxt.next_idx      = match_inc;
        clr                  = 1'b1;
      end
      rpt_pkg::ACT_SNAPSHOT: begin
        st_nxt.mode          = rpt_pkg::MODE_SNAPSHOT;
        st_nxt.probe_pending = 1'b0;
        st_nxt.snap_idx      = item.index;
        clr                  = 1'b1;
      end
      rpt_pkg::ACT_UPDATE: begin
        if (st.match_idx < item.index) begin
          st_nxt.match_idx     = item.index;
          st_nxt.probe_pending = 1'b0;
          success              = 1'b1;
        end
        if (idx_inc > st.next_idx) begin
          st_nxt.next_idx = idx_inc;
        end
      end
      rpt_pkg::ACT_OPTIMISTIC: begin
        st_nxt.next_idx = idx_inc;
      end
      rpt_pkg::ACT_REJECT: begin
        if (st.mode == rpt_pkg::MODE_REPLICATE) begin
          if (item.index > st.match_idx) begin
            st_nxt.next_idx = match_inc;
            success         = 1'b1;
          end
        end else if (next_dec == item.index) begin
          // stale rejects are ignored; next never drops below one
          st_nxt.next_idx      = (hint_min == '0) ? rpt_pkg::IDX_ONE : hint_min;
          st_nxt.probe_pending = 1'b0;
          success              = 1'b1;
        end
      end
      rpt_pkg::ACT_PROBE_FLAG: begin
        st_nxt.probe_pending = item.flag_value;
      end
      rpt_pkg::ACT_ACTIVE: begin
        st_nxt.active = item.flag_value;
      end
      rpt_pkg::ACT_LOAD: begin
        st_nxt.match_idx = item.index;
        st_nxt.next_idx  = item.hint;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.success      = success;
    status.clear_window = clr;
    unique case (st_nxt.mode)
      rpt_pkg::MODE_PROBE:     status.paused = st_nxt.probe_pending;
      rpt_pkg::MODE_REPLICATE: status.paused = !clr && item.window_full;
      default:                 status.paused = 1'b1;
    endcase
  end

endmodule

@@ bench/replication_progress_tracker_tb.sv @@
// Self-checking testbench for the replication progress tracker.
module replication_progress_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W  = rpt_pkg::IDX_W;
  localparam int unsigned ACT_W  = rpt_pkg::ACT_W;
  localparam int unsigned MODE_W = rpt_pkg::MODE_W;

  localparam int unsigned    RAND_ITEMS  = 750;
  localparam int unsigned    LONG_HOLD   = 80;
  localparam int unsigned    DRAIN_LIMIT = 5000;
  localparam logic [IDX_W-1:0] IDX_MAX   = '1;
  // codes past ACT_LOAD decode as a query
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = rpt_pkg::ACT_LOAD + 4'd1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;

  // What one result transfer reports.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  snap_idx;
    logic              success;
    logic              paused;
    logic              clear_window;
    logic              active;
  } follower_view_t;

  // One row of the directed table; 'known' rows carry a hand-written view.
  typedef struct {
    rpt_pkg::item_t it;
    bit             known;
    follower_view_t view;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ACT_W-1:0]  in_action = rpt_pkg::ACT_QUERY;
  logic [IDX_W-1:0]  in_index = '0;
  logic [IDX_W-1:0]  in_hint = '0;
  logic              in_flag_value = 1'b0;
  logic              in_window_full = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MODE_W-1:0] out_mode;
  logic [IDX_W-1:0]  out_match_index;
  logic [IDX_W-1:0]  out_next_index;
  logic [IDX_W-1:0]  out_snapshot_index;
  logic              out_success;
  logic              out_paused;
  logic              out_clear_window;
  logic              out_recently_active;

  // Predictor state: follower progress after every accepted transfer so far.
  rpt_pkg::track_state_t tracker_now;
  follower_view_t        views_due[$];
  step_row_t             steps[$];

  int unsigned errors     = 0;
  int unsigned n_items    = 0;
  int unsigned n_results  = 0;
  int unsigned n_success  = 0;
  int unsigned n_clears   = 0;
  int unsigned n_paused   = 0;

  replication_progress_tracker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_index           (in_index),
    .in_hint            (in_hint),
    .in_flag_value      (in_flag_value),
    .in_window_full     (in_window_full),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mode           (out_mode),
    .out_match_index    (out_match_index),
    .out_next_index     (out_next_index),
    .out_snapshot_index (out_snapshot_index),
    .out_success        (out_success),
    .out_paused         (out_paused),
    .out_clear_window   (out_clear_window),
    .out_recently_active(out_recently_active)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [IDX_W-1:0] umax(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [IDX_W-1:0] umin(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Apply one action to the tracked follower and return the view it produces.
  // All sums land in 64-bit variables, so wraparound matches the hardware.
  function automatic follower_view_t apply_action(rpt_pkg::item_t it);
    follower_view_t   v;
    logic [IDX_W-1:0] old_snap;
    logic             was_snap;
    logic             ok;
    logic             clr;
    ok  = 1'b0;
    clr = 1'b0;
    case (it.action)
      rpt_pkg::ACT_PROBE: begin
        old_snap = tracker_now.snap_idx;
        was_snap = (tracker_now.mode == rpt_pkg::MODE_SNAPSHOT);
        tracker_now.probe_pending = 1'b0;
        tracker_now.snap_idx      = '0;
        tracker_now.mode          = rpt_pkg::MODE_PROBE;
        // leaving snapshot: resume past whichever is further, match or snapshot
        if (was_snap)
          tracker_now.next_idx = umax(tracker_now.match_idx + rpt_pkg::IDX_ONE,
                                      old_snap + rpt_pkg::IDX_ONE);
        else
          tracker_now.next_idx = tracker_now.match_idx + rpt_pkg::IDX_ONE;
        clr = 1'b1;
      end
      rpt_pkg::ACT_REPLICATE: begin
        tracker_now.probe_pending = 1'b0;
        tracker_now.snap_idx      = '0;
        tracker_now.mode          = rpt_pkg::MODE_REPLICATE;
        tracker_now.next_idx      = tracker_now.match_idx + rpt_pkg::IDX_ONE;
        clr = 1'b1;
      end
      rpt_pkg::ACT_SNAPSHOT: begin
        tracker_now.probe_pending = 1'b0;
        tracker_now.mode          = rpt_pkg::MODE_SNAPSHOT;
        tracker_now.snap_idx      = it.index;
        clr = 1'b1;
      end
      rpt_pkg::ACT_UPDATE: begin
        if (tracker_now.match_idx < it.index) begin
          tracker_now.match_idx     = it.index;
          tracker_now.probe_pending = 1'b0;
          ok = 1'b1;
        end
        tracker_now.next_idx = umax(tracker_now.next_idx, it.index + rpt_pkg::IDX_ONE);
      end
      rpt_pkg::ACT_OPTIMISTIC: tracker_now.next_idx = it.index + rpt_pkg::IDX_ONE;
      rpt_pkg::ACT_REJECT: begin
        if (tracker_now.mode == rpt_pkg::MODE_REPLICATE) begin
          // stale rejections (at or below match) are dropped
          if (it.index > tracker_now.match_idx) begin
            tracker_now.next_idx = tracker_now.match_idx + rpt_pkg::IDX_ONE;
            ok = 1'b1;
          end
        end else if (tracker_now.next_idx - rpt_pkg::IDX_ONE == it.index) begin
          // only a rejection of the probe in flight counts
          tracker_now.next_idx      = umax(umin(it.index, it.hint + rpt_pkg::IDX_ONE),
                                           rpt_pkg::IDX_ONE);
          tracker_now.probe_pending = 1'b0;
          ok = 1'b1;
        end
      end
      rpt_pkg::ACT_PROBE_FLAG: tracker_now.probe_pending = it.flag_value;
      rpt_pkg::ACT_ACTIVE:     tracker_now.active        = it.flag_value;
      rpt_pkg::ACT_LOAD: begin
        tracker_now.match_idx = it.index;
        tracker_now.next_idx  = it.hint;
      end
      default: ;
    endcase
    v.mode         = tracker_now.mode;
    v.match_idx    = tracker_now.match_idx;
    v.next_idx     = tracker_now.next_idx;
    v.snap_idx     = tracker_now.snap_idx;
    v.success      = ok;
    v.clear_window = clr;
    v.active       = tracker_now.active;
    // a window reset this cycle leaves the window empty
    if (tracker_now.mode == rpt_pkg::MODE_PROBE)
      v.paused = tracker_now.probe_pending;
    else if (tracker_now.mode == rpt_pkg::MODE_REPLICATE)
      v.paused = clr ? 1'b0 : it.window_full;
    else
      v.paused = 1'b1;
    return v;
  endfunction

  // Index values: mostly close to a base so compares go both ways, some wide.
  function automatic logic [IDX_W-1:0] near(logic [IDX_W-1:0] base);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0)      return {$urandom, $urandom};
    else if (r == 1) return IDX_MAX;
    else if (r == 2) return '0;
    else             return base + IDX_W'($urandom_range(0, 6)) - IDX_W'(3);
  endfunction

  // Random item, steered by the predicted state so that the deeper paths
  // (acks that raise match, rejections of the probe in flight) are hit often.
  function automatic rpt_pkg::item_t pick_item();
    rpt_pkg::item_t it;
    int unsigned    r;
    it.flag_value  = 1'($urandom_range(0, 1));
    it.window_full = 1'($urandom_range(0, 1));
    it.index       = {$urandom, $urandom};
    it.hint        = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.action = rpt_pkg::ACT_QUERY;
    end else if (r < 7) begin
      it.action = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end else if (r < 14) begin
      it.action = rpt_pkg::ACT_PROBE;
    end else if (r < 21) begin
      it.action = rpt_pkg::ACT_REPLICATE;
    end else if (r < 26) begin
      it.action = rpt_pkg::ACT_SNAPSHOT;
      it.index  = near(tracker_now.match_idx + IDX_W'(8));
    end else if (r < 44) begin
      it.action = rpt_pkg::ACT_UPDATE;
      it.index  = near(tracker_now.match_idx + IDX_W'(2));
    end else if (r < 50) begin
      it.action = rpt_pkg::ACT_OPTIMISTIC;
      it.index  = near(tracker_now.next_idx);
    end else if (r < 70) begin
      it.action = rpt_pkg::ACT_REJECT;
      if (tracker_now.mode == rpt_pkg::MODE_REPLICATE) begin
        it.index = near(tracker_now.match_idx);
      end else begin
        it.index = ($urandom_range(0, 9) < 7) ? tracker_now.next_idx - rpt_pkg::IDX_ONE
                                              : near(tracker_now.next_idx);
        if ($urandom_range(0, 3) != 0) it.hint = near(it.index - IDX_W'(4));
      end
    end else if (r < 78) begin
      it.action = rpt_pkg::ACT_PROBE_FLAG;
    end else if (r < 85) begin
      it.action = rpt_pkg::ACT_ACTIVE;
    end else begin
      it.action = rpt_pkg::ACT_LOAD;
      // pull the indices back to a small range most of the time
      if ($urandom_range(0, 3) != 0) begin
        it.index = IDX_W'($urandom_range(0, 1000));
        it.hint  = it.index + IDX_W'($urandom_range(0, 4));
      end
    end
    return it;
  endfunction

  task automatic add_row(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                         input logic [IDX_W-1:0] hint, input logic flag, input logic full,
                         input bit known = 1'b0, input follower_view_t view = '0);
    step_row_t row;
    row.it    = '{act, idx, hint, flag, full};
    row.known = known;
    row.view  = view;
    steps.push_back(row);
  endtask

  // Offer one item after 'gap' idle cycles and hold it until the transfer.
  // With no gap, valid stays high straight into the next item.
  task automatic send_item(input rpt_pkg::item_t it, input int unsigned gap,
                           input bit known = 1'b0, input follower_view_t view = '0);
    follower_view_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_index       <= it.index;
    in_hint        <= it.hint;
    in_flag_value  <= it.flag_value;
    in_window_full <= it.window_full;
    do @(posedge clk); while (!(in_valid && in_ready));
    predicted = apply_action(it);
    views_due.push_back(known ? view : predicted);
    n_items++;
  endtask

  // Sender pause: nothing offered until every outstanding result is back.
  task automatic drain_results();
    int unsigned spins;
    spins = 0;
    in_valid <= 1'b0;
    while (views_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] want,
                             input logic [IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Result side: a random stall before each transfer, stall-free stretches,
  // and two long hold-offs so the block backs up into its input.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 150 || taken == 450) stall = LONG_HOLD;
      else if ((taken / 70) % 4 == 1)   stall = 0;
      else                              stall = $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Compare each result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin
    follower_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (views_due.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
      end else begin
        want = views_due.pop_front();
        check_field("mode",            IDX_W'(want.mode),         IDX_W'(out_mode));
        check_field("match_index",     want.match_idx,            out_match_index);
        check_field("next_index",      want.next_idx,             out_next_index);
        check_field("snapshot_index",  want.snap_idx,             out_snapshot_index);
        check_field("success",         IDX_W'(want.success),      IDX_W'(out_success));
        check_field("paused",          IDX_W'(want.paused),       IDX_W'(out_paused));
        check_field("clear_window",    IDX_W'(want.clear_window), IDX_W'(out_clear_window));
        check_field("recently_active", IDX_W'(want.active),       IDX_W'(out_recently_active));
        n_results++;
        n_success += want.success;
        n_clears  += want.clear_window;
        n_paused  += want.paused;
      end
    end
  end

  initial begin : stimulus
    int unsigned gap_max;
    int unsigned spins;
    tracker_now = '0;

    // Directed table. Comments give the state the row is aiming at.
    // straight out of reset everything reads zero
    add_row(rpt_pkg::ACT_QUERY, '0, '0, 1'b0, 1'b0, 1'b1,
            '{rpt_pkg::MODE_PROBE, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(rpt_pkg::ACT_UPDATE, '0, IDX_MAX, 1'b1, 1'b1);            // ack of 0: no raise
    // load the extremes: match and next both all ones
    add_row(rpt_pkg::ACT_LOAD, IDX_MAX, IDX_MAX, 1'b0, 1'b0, 1'b1,
            '{rpt_pkg::MODE_PROBE, IDX_MAX, IDX_MAX, '0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(rpt_pkg::ACT_UPDATE, IDX_MAX, '0, 1'b0, 1'b0);            // index+1 wraps to 0
    add_row(rpt_pkg::ACT_PROBE, '0, '0, 1'b0, 1'b1);                  // next = match+1 wraps
    add_row(rpt_pkg::ACT_PROBE_FLAG, '0, '0, 1'b1, 1'b0);             // probe mode pauses
    add_row(rpt_pkg::ACT_ACTIVE, '0, '0, 1'b1, 1'b0);
    add_row(rpt_pkg::ACT_REJECT, IDX_MAX, '0, 1'b0, 1'b0);            // probe in flight, floor 1
    add_row(rpt_pkg::ACT_REJECT, IDX_W'(5), '0, 1'b0, 1'b0);          // not the probe: ignored
    add_row(rpt_pkg::ACT_REPLICATE, '0, '0, 1'b0, 1'b1);              // window cleared
    add_row(rpt_pkg::ACT_QUERY, '0, '0, 1'b0, 1'b1);                  // window full: paused
    add_row(rpt_pkg::ACT_LOAD, IDX_W'(100), IDX_W'(200), 1'b0, 1'b0);
    add_row(rpt_pkg::ACT_REJECT, IDX_W'(100), '0, 1'b0, 1'b0);        // stale reject at match
    add_row(rpt_pkg::ACT_REJECT, IDX_W'(150), '0, 1'b0, 1'b0);        // falls back to match+1
    add_row(rpt_pkg::ACT_OPTIMISTIC, IDX_MAX, '0, 1'b0, 1'b0);
    add_row(rpt_pkg::ACT_UPDATE, IDX_W'(120), '0, 1'b0, 1'b1);        // raises match
    add_row(rpt_pkg::ACT_SNAPSHOT, IDX_W'(500), '0, 1'b0, 1'b0);
    add_row(rpt_pkg::ACT_REJECT, IDX_W'(120), IDX_MAX, 1'b0, 1'b0);   // hint+1 wraps to 0
    add_row(rpt_pkg::ACT_PROBE, '0, '0, 1'b0, 1'b0);                  // resumes past snapshot
    add_row(rpt_pkg::ACT_PROBE_FLAG, '0, '0, 1'b1, 1'b0);
    add_row(rpt_pkg::ACT_UPDATE, IDX_W'(130), '0, 1'b0, 1'b0);        // ack clears probe-sent
    add_row(rpt_pkg::ACT_SNAPSHOT, IDX_MAX, '0, 1'b0, 1'b0);
    add_row(rpt_pkg::ACT_PROBE, '0, '0, 1'b0, 1'b0);                  // snapshot+1 wraps
    add_row(ACT_UNUSED_HI, IDX_MAX, IDX_MAX, 1'b1, 1'b1);             // undefined code: query
    add_row(ACT_UNUSED_LO, '0, '0, 1'b0, 1'b0);
    add_row(rpt_pkg::ACT_ACTIVE, '0, '0, 1'b0, 1'b0);

    // single reset at the start of the run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i])
      send_item(steps[i].it, $urandom_range(0, 8), steps[i].known, steps[i].view);
    drain_results();

    // Random part: bursts with no gaps alternate with stretches of random gaps;
    // one pause in the middle lets every result come back first.
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) drain_results();
      gap_max = ((n / 60) % 3 == 0) ? 0 : 8;
      send_item(pick_item(), $urandom_range(0, gap_max));
    end

    in_valid <= 1'b0;
    spins = 0;
    while (views_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    // keep waiting after the drain to catch any stray result
    repeat (8) @(posedge clk);
    if (views_due.size() != 0) begin
      $error("%0d results never arrived", views_due.size());
      errors++;
    end

    $display("%0d items (%0d directed, rest random) sent, %0d results checked",
             n_items, steps.size(), n_results);
    $display("%0d results with success, %0d window clears, %0d paused",
             n_success, n_clears, n_paused);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #500_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
